FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL. Compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define ASSERT_ON(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_ON(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: design/cpr_pkg.sv
`default_nettype none

package cpr_pkg;

  localparam int          HEADER_BYTES      = 12;
  localparam logic [31:0] CRC_POLY          = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT          = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_MSB           = 32'h80000000;
  localparam logic [2:0]  RETRY_LIMIT_RESET = 3'd3;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_NEXT  = 2'd0,
    VERDICT_DONE  = 2'd1,
    VERDICT_RETRY = 2'd2,
    VERDICT_FAIL  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] sample;
    logic [1:0]  channel;
    verdict_t    verdict;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

  typedef logic [31:0] crc_cols_t [32];

  // Column i of the word-update matrix: the CRC after 32 shifts of a lone bit i.
  function automatic crc_cols_t crc_cols();
    crc_cols_t   cols;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'(1) << i;
      for (int b = 0; b < 32; b++) begin
        if ((c & CRC_MSB) != 32'd0) begin
          c = (c << 1) ^ CRC_POLY;
        end else begin
          c = c << 1;
        end
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_cols();

endpackage

`default_nettype wire

FILE: design/cpr_crc32.sv
`default_nettype none

module cpr_crc32 (
  input  logic [31:0] crc,
  input  logic [31:0] word,
  output logic [31:0] crc_next
);

  logic [31:0] x;

  assign x = crc ^ word;

  always_comb begin
    crc_next = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        crc_next = crc_next ^ cpr_pkg::CRC_COLS[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/cpr_out_fifo.sv
`default_nettype none
`include "assert_macros.svh"

module cpr_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  cpr_pkg::result_t push_a,
  input  cpr_pkg::result_t push_b,
  output logic             space2,
  output logic             out_valid,
  input  logic             out_ready,
  output cpr_pkg::result_t head
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = PW + 1;

  cpr_pkg::result_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign space2    = (count <= CNTW'(DEPTH - 2));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CNTW'(push_n) - CNTW'(pop);
    end
  end

  `ASSERT_ON(a_count_bound, clk, rst, count <= CNTW'(DEPTH))
  `ASSERT_ON(a_count_track, clk, rst,
    1'b1 |=> count == CNTW'($past(count) + CNTW'($past(push_n)) - CNTW'($past(pop))))

endmodule

`default_nettype wire

FILE: design/cpr_parser.sv
`default_nettype none
`include "assert_macros.svh"

module cpr_parser #(
  parameter int CHANNELS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write_en,
  input  logic [2:0]     cfg_write_data,
  input  logic           step_en,
  input  logic           command,
  input  logic [7:0]     rx_byte,
  output cpr_pkg::step_t step
);

  localparam int            CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CW-1:0] CH_LAST = CW'(CHANNELS - 1);

  localparam logic [3:0] HDR_CRC_END    = 4'd4;
  localparam logic [3:0] HDR_PKT_TOTAL  = 4'd6;
  localparam logic [3:0] HDR_PKT_NUMBER = 4'd7;
  localparam logic [3:0] HDR_SIZE_LO    = 4'd8;
  localparam logic [3:0] HDR_SIZE_HI    = 4'd9;
  localparam logic [3:0] HDR_LAST       = 4'(cpr_pkg::HEADER_BYTES - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  phase_t        phase,             phase_next;
  logic [3:0]    header_count,      header_count_next;
  logic [31:0]   header_crc,        header_crc_next;
  logic [7:0]    pkt_total,         pkt_total_next;
  logic [7:0]    pkt_number,        pkt_number_next;
  logic [15:0]   payload_size,      payload_size_next;
  logic [15:0]   payload_count,     payload_count_next;
  logic [31:0]   crc_reg,           crc_reg_next;
  logic [23:0]   word_bytes,        word_bytes_next;
  logic [CW-1:0] committed_channel, committed_channel_next;
  logic [CW-1:0] working_channel,   working_channel_next;
  logic [2:0]    retry_count,       retry_count_next;
  logic [2:0]    retry_limit;

  logic [31:0]   crc_word_out;
  logic [CW+1:0] wc_ext;

  cpr_crc32 u_crc (
    .crc      (crc_reg),
    .word     ({rx_byte, word_bytes}),
    .crc_next (crc_word_out)
  );

  assign wc_ext = (CW + 2)'(working_channel);

  always_comb begin
    logic              do_decide;
    logic              has_sample;
    logic [31:0]       got;
    logic [15:0]       cnt_inc;
    logic [1:0]        pos;
    cpr_pkg::verdict_t v;
    cpr_pkg::result_t  sres;
    cpr_pkg::result_t  vres;

    phase_next             = phase;
    header_count_next      = header_count;
    header_crc_next        = header_crc;
    pkt_total_next         = pkt_total;
    pkt_number_next        = pkt_number;
    payload_size_next      = payload_size;
    payload_count_next     = payload_count;
    crc_reg_next           = crc_reg;
    word_bytes_next        = word_bytes;
    committed_channel_next = committed_channel;
    working_channel_next   = working_channel;
    retry_count_next       = retry_count;

    do_decide  = 1'b0;
    has_sample = 1'b0;
    got        = cpr_pkg::CRC_INIT;
    cnt_inc    = payload_count + 16'd1;
    pos        = payload_count[1:0];
    v          = cpr_pkg::VERDICT_NEXT;
    sres       = '0;
    vres       = '0;
    step       = '0;

    if (command) begin
      phase_next             = PH_HEADER;
      header_count_next      = '0;
      header_crc_next        = '0;
      pkt_total_next         = '0;
      pkt_number_next        = '0;
      payload_size_next      = '0;
      payload_count_next     = '0;
      crc_reg_next           = cpr_pkg::CRC_INIT;
      word_bytes_next        = '0;
      committed_channel_next = '0;
      working_channel_next   = '0;
      retry_count_next       = '0;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (header_count < HDR_CRC_END) begin
            header_crc_next[{header_count[1:0], 3'b000} +: 8] = rx_byte;
          end else if (header_count == HDR_PKT_TOTAL) begin
            pkt_total_next = rx_byte;
          end else if (header_count == HDR_PKT_NUMBER) begin
            pkt_number_next = rx_byte;
          end else if (header_count == HDR_SIZE_LO) begin
            payload_size_next[7:0] = rx_byte;
          end else if (header_count == HDR_SIZE_HI) begin
            payload_size_next[15:8] = rx_byte;
          end
          if (header_count >= HDR_LAST) begin
            header_count_next  = '0;
            payload_count_next = '0;
            crc_reg_next       = cpr_pkg::CRC_INIT;
            word_bytes_next    = '0;
            phase_next         = PH_PAYLOAD;
            if (payload_size_next == 16'd0) begin
              do_decide = 1'b1;
              got       = cpr_pkg::CRC_INIT;
            end
          end else begin
            header_count_next = header_count + 4'd1;
          end
        end
        PH_PAYLOAD: begin
          if (pos[0]) begin
            has_sample     = 1'b1;
            sres.kind      = cpr_pkg::KIND_SAMPLE;
            sres.sample    = {rx_byte, pos[1] ? word_bytes[23:16] : word_bytes[7:0]};
            sres.channel   = wc_ext[1:0];
            working_channel_next = (working_channel == CH_LAST) ? '0
                                                                : working_channel + CW'(1);
          end
          if (pos == 2'd3) begin
            crc_reg_next    = crc_word_out;
            word_bytes_next = '0;
          end else begin
            word_bytes_next[{pos, 3'b000} +: 8] = rx_byte;
          end
          payload_count_next = cnt_inc;
          if (cnt_inc >= payload_size) begin
            do_decide = 1'b1;
            got       = (payload_size[1:0] != 2'd0) ? 32'd0 : crc_reg_next;
          end
        end
        default: ;
      endcase
    end

    if (do_decide) begin
      if (got != header_crc_next) begin
        if (retry_count < retry_limit) begin
          v                    = cpr_pkg::VERDICT_RETRY;
          retry_count_next     = retry_count + 3'd1;
          working_channel_next = committed_channel;
          phase_next           = PH_HEADER;
          header_count_next    = '0;
        end else begin
          v          = cpr_pkg::VERDICT_FAIL;
          phase_next = PH_IDLE;
        end
      end else begin
        retry_count_next       = '0;
        committed_channel_next = working_channel_next;
        if (({1'b0, pkt_number_next} + 9'd1) < {1'b0, pkt_total_next}) begin
          v                 = cpr_pkg::VERDICT_NEXT;
          phase_next        = PH_HEADER;
          header_count_next = '0;
        end else begin
          v          = cpr_pkg::VERDICT_DONE;
          phase_next = PH_IDLE;
        end
      end
    end

    vres.kind    = cpr_pkg::KIND_VERDICT;
    vres.verdict = v;
    vres.last    = 1'b1;

    if (has_sample && do_decide) begin
      step.count  = 2'd2;
      step.first  = sres;
      step.second = vres;
    end else if (has_sample) begin
      step.count      = 2'd1;
      step.first      = sres;
      step.first.last = 1'b1;
    end else if (do_decide) begin
      step.count = 2'd1;
      step.first = vres;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= cpr_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_write_en) begin
      retry_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      header_count      <= '0;
      header_crc        <= '0;
      pkt_total         <= '0;
      pkt_number        <= '0;
      payload_size      <= '0;
      payload_count     <= '0;
      crc_reg           <= cpr_pkg::CRC_INIT;
      word_bytes        <= '0;
      committed_channel <= '0;
      working_channel   <= '0;
      retry_count       <= '0;
    end else if (step_en) begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      header_crc        <= header_crc_next;
      pkt_total         <= pkt_total_next;
      pkt_number        <= pkt_number_next;
      payload_size      <= payload_size_next;
      payload_count     <= payload_count_next;
      crc_reg           <= crc_reg_next;
      word_bytes        <= word_bytes_next;
      committed_channel <= committed_channel_next;
      working_channel   <= working_channel_next;
      retry_count       <= retry_count_next;
    end
  end

  `ASSERT_ON(a_idle_silent, clk, rst,
    step_en && !command && phase == PH_IDLE |-> step.count == 2'd0)
  `ASSERT_ON(a_pair_order, clk, rst,
    step.count == 2'd2 |-> step.first.kind == cpr_pkg::KIND_SAMPLE &&
      step.second.kind == cpr_pkg::KIND_VERDICT && !step.first.last)
  `ASSERT_ON(a_start_clears, clk, rst,
    step_en && command |=> phase == PH_HEADER && retry_count == 3'd0 &&
      header_count == 4'd0)

endmodule

`default_nettype wire

FILE: design/crc_checked_packet_receiver.sv
// CRC-checked packet receiver.
// Input channel (in_valid/in_ready): one beat carries command and rx_byte.
// command 1 starts a transfer; command 0 delivers a link byte. Each packet is
// a 12-byte header (CRC, count, index, size) followed by the payload bytes.
// Output channel (out_valid/out_ready): one beat per result, either a 16-bit
// sample with its channel (kind 0) or a packet verdict (kind 1); last marks
// the final result caused by one input beat. A byte may cause two results.
// Each input beat is registered, and its results are queued for the output.
// Throughput: one input beat per cycle while two entries are free; the payload CRC
// is a combinational XOR matrix per 32-bit word; one result out per ready cycle.
// A four-entry result queue sits behind the parser; an input beat is taken
// only while two entries are free, so a stalled receiver backs up into
// in_ready after the queue and the input register fill.
// cfg_write_en/cfg_write_data set the resend limit (reset 3); write only when idle.
// Reset (rst, synchronous) empties the queue and returns the parser to idle.
`default_nettype none

module crc_checked_packet_receiver #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [15:0] sample,
  output logic [1:0]  channel,
  output logic [1:0]  verdict,
  output logic        last
);

  logic             ireg_valid;
  logic             ireg_command;
  logic [7:0]       ireg_byte;
  logic             step_en;
  logic             space2;
  logic [1:0]       push_n;
  cpr_pkg::step_t   step;
  cpr_pkg::result_t head;

  assign step_en  = ireg_valid && space2;
  assign in_ready = !ireg_valid || step_en;
  assign push_n   = step_en ? step.count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg_command <= command;
      ireg_byte    <= rx_byte;
    end
  end

  cpr_parser #(
    .CHANNELS (CHANNELS)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .step_en        (step_en),
    .command        (ireg_command),
    .rx_byte        (ireg_byte),
    .step           (step)
  );

  cpr_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_a    (step.first),
    .push_b    (step.second),
    .space2    (space2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind    = head.kind;
  assign sample  = head.sample;
  assign channel = head.channel;
  assign verdict = head.verdict;
  assign last    = head.last;

endmodule

`default_nettype wire

FILE: tb/cpr_result_checker.sv
`timescale 1ns / 100ps

package cpr_tb_pkg;
  import cpr_pkg::*;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // MSB-first CRC-32 over one 32-bit word, bit at a time
  function automatic logic [31:0] crc_fold_word(logic [31:0] crc, logic [31:0] word);
    logic [31:0] c;
    c = crc ^ word;
    for (int b = 0; b < 32; b++) begin
      if ((c & CRC_MSB) != 32'd0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction
endpackage

module cpr_result_checker #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_write_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        kind,
  input  logic [15:0] sample,
  input  logic [1:0]  channel,
  input  logic [1:0]  verdict,
  input  logic        last,
  output int          pending,
  output int          mismatches
);
  import cpr_pkg::*;
  import cpr_tb_pkg::*;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_HEADER,
    RX_PAYLOAD
  } rx_phase_t;

  logic [2:0]  resend_limit;
  rx_phase_t   rx_phase;
  logic [3:0]  hdr_pos;
  logic [31:0] hdr_crc;
  logic [7:0]  pkt_count;
  logic [7:0]  pkt_index;
  logic [15:0] pay_size;
  logic [15:0] pay_pos;
  logic [31:0] crc_acc;
  logic [23:0] open_word;
  int unsigned good_chan;
  int unsigned cur_chan;
  logic [2:0]  retries_used;

  result_t expected_results[$];

  initial mismatches = 0;

  function automatic void clear_transfer();
    hdr_pos      = '0;
    hdr_crc      = '0;
    pkt_count    = '0;
    pkt_index    = '0;
    pay_size     = '0;
    pay_pos      = '0;
    crc_acc      = CRC_INIT;
    open_word    = '0;
    good_chan    = 0;
    cur_chan     = 0;
    retries_used = '0;
  endfunction

  function automatic result_t verdict_result(verdict_t v);
    result_t r;
    r         = '0;
    r.kind    = KIND_VERDICT;
    r.verdict = v;
    return r;
  endfunction

  // End of payload: CRC compare, retry/rollback bookkeeping
  function automatic verdict_t close_packet();
    logic [31:0] computed;
    computed = (pay_size[1:0] != 2'd0) ? 32'd0 : crc_acc;
    if (computed != hdr_crc) begin
      if (retries_used < resend_limit) begin
        retries_used = retries_used + 3'd1;
        cur_chan     = good_chan;
        rx_phase     = RX_HEADER;
        hdr_pos      = '0;
        return VERDICT_RETRY;
      end
      rx_phase = RX_IDLE;
      return VERDICT_FAIL;
    end
    retries_used = '0;
    good_chan    = cur_chan;
    if (int'(pkt_index) + 1 < int'(pkt_count)) begin
      rx_phase = RX_HEADER;
      hdr_pos  = '0;
      return VERDICT_NEXT;
    end
    rx_phase = RX_IDLE;
    return VERDICT_DONE;
  endfunction

  task automatic predict_beat(input logic cmd, input logic [7:0] b);
    result_t    made[2];
    int         n;
    logic [1:0] pos;
    n = 0;
    if (cmd == CMD_START) begin
      clear_transfer();
      rx_phase = RX_HEADER;
      return;
    end
    case (rx_phase)
      RX_HEADER: begin
        if (hdr_pos < 4'd4) begin
          hdr_crc[8*int'(hdr_pos) +: 8] = b;
        end else if (hdr_pos == 4'd6) begin
          pkt_count = b;
        end else if (hdr_pos == 4'd7) begin
          pkt_index = b;
        end else if (hdr_pos == 4'd8) begin
          pay_size[7:0] = b;
        end else if (hdr_pos == 4'd9) begin
          pay_size[15:8] = b;
        end
        if (int'(hdr_pos) == HEADER_BYTES - 1) begin
          hdr_pos   = '0;
          pay_pos   = '0;
          crc_acc   = CRC_INIT;
          open_word = '0;
          rx_phase  = RX_PAYLOAD;
          if (pay_size == 16'd0) begin
            made[n] = verdict_result(close_packet());
            n++;
          end
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      RX_PAYLOAD: begin
        pos = pay_pos[1:0];
        if (pos[0]) begin
          made[n]         = '0;
          made[n].kind    = KIND_SAMPLE;
          made[n].sample  = {b, open_word[8*(int'(pos)-1) +: 8]};
          made[n].channel = cur_chan[1:0];
          made[n].verdict = VERDICT_NEXT;
          n++;
          cur_chan = (cur_chan + 1) % CHANNELS;
        end
        if (pos == 2'd3) begin
          crc_acc   = crc_fold_word(crc_acc, {b, open_word});
          open_word = '0;
        end else begin
          open_word[8*int'(pos) +: 8] = b;
        end
        pay_pos = pay_pos + 16'd1;
        if (pay_pos >= pay_size) begin
          made[n] = verdict_result(close_packet());
          n++;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      expected_results = {expected_results, made[i]};
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_transfer();
      rx_phase     = RX_IDLE;
      resend_limit = RETRY_LIMIT_RESET;
      expected_results.delete();
    end else begin
      if (cfg_write_en) begin
        resend_limit = cfg_write_data;
      end
      if (in_valid && in_ready) begin
        predict_beat(command, rx_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: kind %0d sample %0d verdict %0d",
                 kind, sample, verdict);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("kind", 16'(want.kind), 16'(kind));
          compare_field("sample", want.sample, sample);
          compare_field("channel", 16'(want.channel), 16'(channel));
          compare_field("verdict", 16'(want.verdict), 16'(verdict));
          compare_field("last", 16'(want.last), 16'(last));
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

FILE: tb/tb_crc_checked_packet_receiver.sv
`timescale 1ns / 100ps

module tb_crc_checked_packet_receiver;
  import cpr_pkg::*;
  import cpr_tb_pkg::*;

  localparam int CHANNELS      = 4;
  localparam int SEG_BEATS     = 150;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 300000;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        cfg_write_en   = 1'b0;
  logic [2:0]  cfg_write_data = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        command        = CMD_BYTE;
  logic [7:0]  rx_byte        = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        kind;
  logic [15:0] sample;
  logic [1:0]  channel;
  logic [1:0]  verdict;
  logic        last;

  int          pending_results;
  int          mismatch_count;
  int unsigned cycle_count    = 0;
  int unsigned useful_beats   = 0;
  int unsigned send_idle_pct  = 13;
  int unsigned recv_idle_pct  = 70;
  logic [2:0]  resend_setting = RETRY_LIMIT_RESET;

  crc_checked_packet_receiver #(
    .CHANNELS(CHANNELS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .sample        (sample),
    .channel       (channel),
    .verdict       (verdict),
    .last          (last)
  );

  cpr_result_checker #(
    .CHANNELS(CHANNELS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .sample        (sample),
    .channel       (channel),
    .verdict       (verdict),
    .last          (last),
    .pending       (pending_results),
    .mismatches    (mismatch_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One input beat; valid held until accepted
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_header(input logic [31:0] crc, input logic [7:0] total,
                             input logic [7:0] index, input logic [15:0] size);
    logic [7:0] hdr[12];
    hdr[0]  = crc[7:0];
    hdr[1]  = crc[15:8];
    hdr[2]  = crc[23:16];
    hdr[3]  = crc[31:24];
    hdr[4]  = 8'($urandom_range(255));
    hdr[5]  = 8'($urandom_range(255));
    hdr[6]  = total;
    hdr[7]  = index;
    hdr[8]  = size[7:0];
    hdr[9]  = size[15:8];
    hdr[10] = 8'($urandom_range(255));
    hdr[11] = 8'($urandom_range(255));
    foreach (hdr[i]) send_beat(CMD_BYTE, hdr[i]);
    useful_beats += 12;
  endtask

  // spoil: stored CRC made wrong so the packet is refused
  task automatic send_packet(input logic [7:0] total, input logic [7:0] index,
                             input int unsigned size, input bit spoil);
    logic [7:0]  body[$];
    logic [31:0] crc;
    logic [31:0] flip;
    for (int i = 0; i < size; i++) body = {body, 8'($urandom_range(255))};
    crc = CRC_INIT;
    for (int w = 0; w + 4 <= size; w += 4) begin
      crc = crc_fold_word(crc, {body[w+3], body[w+2], body[w+1], body[w]});
    end
    if (size % 4 != 0) crc = '0;
    if (spoil) begin
      flip = $urandom;
      if (flip == '0) flip = 32'd1;
      crc ^= flip;
    end
    send_header(crc, total, index, 16'(size));
    foreach (body[i]) send_beat(CMD_BYTE, body[i]);
    useful_beats += size;
  endtask

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(1, 24);
    if (r < 97) return $urandom_range(25, 64);
    return $urandom_range(250, 300);
  endfunction

  // Well-formed transfer, resends tracked against the current limit
  task automatic run_transfer();
    int unsigned packets;
    int unsigned pkt;
    int unsigned tries;
    bit          bad;
    logic [7:0]  total_field;
    send_beat(CMD_START, 8'($urandom_range(255)));
    useful_beats++;
    packets = $urandom_range(1, 4);
    pkt     = 0;
    tries   = 0;
    while (pkt < packets) begin
      bad         = ($urandom_range(99) < 30);
      total_field = 8'(packets);
      if (pkt == packets - 1 && $urandom_range(7) == 0) total_field = '0;
      send_packet(total_field, 8'(pkt), pick_size(), bad);
      if (bad) begin
        if (tries >= resend_setting) return;
        tries++;
      end else begin
        tries = 0;
        pkt++;
      end
    end
    // stray bytes while idle
    if ($urandom_range(9) == 0) begin
      send_beat(CMD_BYTE, 8'($urandom_range(255)));
    end
  endtask

  // Start then raw noise: random header, truncated packets
  task automatic send_fragment();
    int unsigned k;
    k = $urandom_range(1, 30);
    send_beat(CMD_START, 8'($urandom_range(255)));
    for (int i = 0; i < k; i++) send_beat(CMD_BYTE, 8'($urandom_range(255)));
    useful_beats += k + 1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_resends(input logic [2:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    resend_setting = v;
  endtask

  initial begin
    int unsigned seg_resends[6] = '{7, 0, 2, 5, 0, 7};
    int unsigned target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, limit at reset value
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_START, 8'hA5);
    send_packet(8'h00, 8'h00, 0, 1'b0);
    send_beat(CMD_START, 8'h00);
    send_packet(8'd2, 8'd0, 4, 1'b0);
    send_packet(8'd2, 8'd1, 7, 1'b1);
    send_packet(8'd2, 8'd1, 6, 1'b0);
    send_beat(CMD_START, 8'h00);
    send_packet(8'd1, 8'd0, 0, 1'b1);
    send_packet(8'd1, 8'd0, 0, 1'b0);
    send_beat(CMD_START, 8'h00);
    repeat (4) send_packet(8'd1, 8'd0, 5, 1'b1);
    send_beat(CMD_START, 8'h00);
    send_packet(8'hFF, 8'hFE, 2, 1'b0);
    send_packet(8'hFF, 8'hFF, 9, 1'b0);
    // huge size, cut short by a new start
    send_beat(CMD_START, 8'h00);
    send_header(32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_START, 8'hFF);
    send_beat(CMD_BYTE, 8'h12);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg / 2 == 1) begin
        send_idle_pct = 70;
        recv_idle_pct = 13;
      end else if (seg / 2 == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_resends((seg == 3) ? 3'($urandom_range(1, 6)) : 3'(seg_resends[seg]));
      target = useful_beats + SEG_BEATS;
      while (useful_beats < target) begin
        if ($urandom_range(99) < 8) begin
          send_fragment();
        end else begin
          run_transfer();
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/cpr_pkg.sv
design/cpr_crc32.sv
design/cpr_out_fifo.sv
design/cpr_parser.sv
design/crc_checked_packet_receiver.sv
tb/cpr_result_checker.sv
tb/tb_crc_checked_packet_receiver.sv
